// ===== rtl/adsr_pkg.sv =====
// Shared types, codes and constants of the ADSR envelope shaper.
`default_nettype none
package adsr_pkg;

  // Default field widths.
  localparam int unsigned SAMPLE_WIDTH_DEF = 16;
  localparam int unsigned LENGTH_WIDTH_DEF = 22;

  // Envelope values are unsigned Q1.15 up to 1.0, carried as 17-bit signed operands.
  localparam int unsigned ENV_W  = 17;
  localparam int unsigned QUOT_W = 16;
  localparam int unsigned SUS_W  = 16;

  localparam logic [ENV_W-1:0] ENV_ONE = 17'h08000;
  localparam logic [SUS_W-1:0] SUS_ONE = 16'h8000;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_LEN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_LEN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN_LVL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_LEN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SOUND_LEN   = 3'd4;

  // Register reset values.
  localparam int unsigned ATTACK_LEN_RST  = 441;
  localparam int unsigned DECAY_LEN_RST   = 4410;
  localparam int unsigned SUSTAIN_LVL_RST = 22938;
  localparam int unsigned RELEASE_LEN_RST = 8820;
  localparam int unsigned SOUND_LEN_RST   = 44100;

  typedef enum logic [1:0] {
    PH_ATTACK  = 2'd0,
    PH_DECAY   = 2'd1,
    PH_SUSTAIN = 2'd2,
    PH_RELEASE = 2'd3
  } phase_e;

endpackage
`default_nettype wire

// ===== rtl/adsr_if.sv =====
// Valid/ready channel interfaces for the sample input and the shaped output.
`default_nettype none
interface adsr_in_if #(
  parameter int unsigned SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;
  logic                           start_req;

  modport source (output valid, output sample_in, output start_req, input ready);
  modport sink   (input valid, input sample_in, input start_req, output ready);
endinterface

interface adsr_out_if #(
  parameter int unsigned SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;
  logic [1:0]                     phase;

  modport source (output valid, output sample_out, output phase, input ready);
  modport sink   (input valid, input sample_out, input phase, output ready);
endinterface
`default_nettype wire

// ===== rtl/adsr_mul.sv =====
// Registered signed multiplier shared by the numerator and the final scaling.
`default_nettype none
module adsr_mul #(
  parameter int unsigned A_WIDTH = 23,
  parameter int unsigned B_WIDTH = 17
) (
  input  logic                              clk_i,
  input  logic signed [A_WIDTH-1:0]         a_i,
  input  logic signed [B_WIDTH-1:0]         b_i,
  output logic signed [A_WIDTH+B_WIDTH-1:0] p_o
);
  logic signed [A_WIDTH+B_WIDTH-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= (A_WIDTH + B_WIDTH)'(a_i) * (A_WIDTH + B_WIDTH)'(b_i);
  end

  assign p_o = p_q;
endmodule
`default_nettype wire

// ===== rtl/adsr_div.sv =====
// Radix-2 restoring divider producing one quotient bit per cycle.
`default_nettype none
module adsr_div #(
  parameter int unsigned DEN_WIDTH  = 22,
  parameter int unsigned QUOT_WIDTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [DEN_WIDTH+QUOT_WIDTH-1:0] num_i,
  input  logic [DEN_WIDTH-1:0]            den_i,
  output logic                            done_o,
  output logic [QUOT_WIDTH-1:0]           quot_o
);
  localparam int unsigned CW = $clog2(QUOT_WIDTH);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [DEN_WIDTH-1:0]  rem_q, rem_d;
  logic [DEN_WIDTH-1:0]  den_q, den_d;
  logic [QUOT_WIDTH-1:0] bits_q, bits_d;
  logic [DEN_WIDTH:0]    trial;
  logic                  fits;

  // The caller guarantees the upper numerator part is below the divisor,
  // so the quotient fits in QUOT_WIDTH bits.
  always_comb begin
    trial  = {rem_q, bits_q[QUOT_WIDTH-1]};
    fits   = trial >= {1'b0, den_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    bits_d = bits_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = num_i[DEN_WIDTH+QUOT_WIDTH-1:QUOT_WIDTH];
      bits_d = num_i[QUOT_WIDTH-1:0];
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d  = fits ? DEN_WIDTH'(trial - {1'b0, den_q}) : trial[DEN_WIDTH-1:0];
      bits_d = {bits_q[QUOT_WIDTH-2:0], fits};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CW'(QUOT_WIDTH - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    bits_q <= bits_d;
  end

  assign done_o = done_q;
  assign quot_o = bits_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_q |-> rem_q < den_q)
    else $error("divider remainder not below divisor");
  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |-> !busy_q)
    else $error("divider started while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> !busy_q && !$past(done_q))
    else $error("divider done is not a single pulse after the last step");
`endif
endmodule
`default_nettype wire

// ===== rtl/adsr_envelope_shaper.sv =====
// Top level of the ADSR envelope shaper: registers, sequencer and output word register.
// Each input word is scaled by an attack/decay/sustain/release envelope chosen by a running
// sample index (start_req restarts it at zero). No new word is taken while one is computed.
// Attack, decay and release ramps need a division, sustain and the part past the sound end
// do not; the shared 16-step radix-2 divider does it, with one shared registered multiplier
// used before it for the numerator and after it for scaling.
// The result sits in an output register, so the next word is taken while it waits.
// Configuration writes are meant for idle periods only.
`default_nettype none
module adsr_envelope_shaper #(
  parameter int unsigned SAMPLE_WIDTH = adsr_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned LENGTH_WIDTH = adsr_pkg::LENGTH_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [adsr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [LENGTH_WIDTH-1:0]          cfg_data_i,
  adsr_in_if.sink                          in_i,
  adsr_out_if.source                       out_o
);
  import adsr_pkg::*;

  localparam int unsigned LW = LENGTH_WIDTH;
  localparam int unsigned SW = SAMPLE_WIDTH;
  localparam int unsigned MW = ((LW > SW) ? LW : SW) + 1;
  localparam int unsigned PW = MW + ENV_W;
  localparam int unsigned NW = LW + QUOT_W;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_SEL  = 8'b0000_0010,
    ST_MUL  = 8'b0000_0100,
    ST_DLD  = 8'b0000_1000,
    ST_DIV  = 8'b0001_0000,
    ST_ENV  = 8'b0010_0000,
    ST_PROD = 8'b0100_0000,
    ST_DONE = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [LW-1:0]    attack_q, decay_q, release_q, length_q;
  logic [SUS_W-1:0] sustain_q;
  logic [LW-1:0]    idx_q;
  logic [LW-1:0]    cur_i_q;
  logic signed [SW-1:0] smp_q;
  phase_e           ph_q;
  logic signed [MW-1:0]    mul_a_q;
  logic signed [ENV_W-1:0] mul_b_q;
  logic [LW-1:0]    dvs_q;
  logic [ENV_W-1:0] env_q;
  logic             out_valid_q;
  logic signed [SW-1:0] out_smp_q;
  phase_e           out_ph_q;

  logic             in_acc;
  logic [LW-1:0]    i_new;
  logic             out_free;
  logic signed [PW-1:0] prod;
  logic             div_start, div_done;
  logic [QUOT_W-1:0] quot;

  // Envelope selection terms.
  logic [SUS_W-1:0] sus_sat;
  logic [LW-1:0]    rel_clip, rel_start;
  logic [LW:0]      ad_sum;
  logic             in_attack, in_decay, in_release, past_end;

  assign in_acc   = in_i.valid && in_i.ready;
  assign i_new    = in_i.start_req ? '0 : idx_q;
  assign out_free = !out_valid_q || out_o.ready;

  assign sus_sat    = (sustain_q > SUS_ONE) ? SUS_ONE : sustain_q;
  assign rel_clip   = (release_q > length_q) ? length_q : release_q;
  assign rel_start  = length_q - rel_clip;
  assign ad_sum     = {1'b0, attack_q} + {1'b0, decay_q};
  assign in_attack  = cur_i_q < attack_q;
  assign in_decay   = {1'b0, cur_i_q} < ad_sum;
  assign in_release = (rel_clip != '0) && (cur_i_q > rel_start);
  // Once inside release, the remaining ramp length r-k equals length-i.
  assign past_end   = cur_i_q >= length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= LW'(ATTACK_LEN_RST);
      decay_q   <= LW'(DECAY_LEN_RST);
      sustain_q <= SUS_W'(SUSTAIN_LVL_RST);
      release_q <= LW'(RELEASE_LEN_RST);
      length_q  <= LW'(SOUND_LEN_RST);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ATTACK_LEN:  attack_q  <= cfg_data_i;
        REG_DECAY_LEN:   decay_q   <= cfg_data_i;
        REG_SUSTAIN_LVL: sustain_q <= cfg_data_i[SUS_W-1:0];
        REG_RELEASE_LEN: release_q <= cfg_data_i;
        REG_SOUND_LEN:   length_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_SEL;
      ST_SEL: begin
        if (!in_attack && !in_decay && (!in_release || past_end)) begin
          state_d = ST_ENV;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_MUL:  state_d = ST_DLD;
      ST_DLD:  state_d = ST_DIV;
      ST_DIV:  if (div_done) state_d = ST_ENV;
      ST_ENV:  state_d = ST_PROD;
      ST_PROD: state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        idx_q <= (&i_new) ? i_new : i_new + 1'b1;
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cur_i_q <= i_new;
      smp_q   <= in_i.sample_in;
    end
    case (state_q)
      ST_SEL: begin
        if (in_attack) begin
          ph_q    <= PH_ATTACK;
          mul_a_q <= MW'(cur_i_q);
          mul_b_q <= ENV_ONE;
          dvs_q   <= attack_q;
        end else if (in_decay) begin
          ph_q    <= PH_DECAY;
          mul_a_q <= MW'(cur_i_q - attack_q);
          mul_b_q <= ENV_ONE - {1'b0, sus_sat};
          dvs_q   <= decay_q;
        end else if (in_release) begin
          ph_q    <= PH_RELEASE;
          mul_a_q <= MW'(length_q - cur_i_q);
          mul_b_q <= {1'b0, sus_sat};
          dvs_q   <= rel_clip;
          env_q   <= '0;
        end else begin
          ph_q    <= PH_SUSTAIN;
          env_q   <= {1'b0, sus_sat};
        end
      end
      ST_DIV: begin
        if (div_done) begin
          env_q <= (ph_q == PH_DECAY) ? ENV_ONE - {1'b0, quot} : {1'b0, quot};
        end
      end
      ST_ENV: begin
        mul_a_q <= MW'(smp_q);
        mul_b_q <= env_q;
      end
      ST_DONE: begin
        if (out_free) begin
          out_smp_q <= prod[SW+14:15];
          out_ph_q  <= ph_q;
        end
      end
      default: ;
    endcase
  end

  assign div_start = state_q == ST_DLD;

  adsr_mul #(
    .A_WIDTH (MW),
    .B_WIDTH (ENV_W)
  ) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a_q),
    .b_i   (mul_b_q),
    .p_o   (prod)
  );

  adsr_div #(
    .DEN_WIDTH  (LW),
    .QUOT_WIDTH (QUOT_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod[NW-1:0]),
    .den_i   (dvs_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign in_i.ready       = state_q == ST_IDLE;
  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_smp_q;
  assign out_o.phase      = out_ph_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("sequencer state is not one-hot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      in_acc && in_i.start_req |=> idx_q == LW'(1))
    else $error("start request did not restart the sample index");
  assert property (@(posedge clk_i) disable iff (!rst_ni) div_done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide step");
  assert property (@(posedge clk_i) disable iff (!rst_ni) state_q == ST_PROD |-> env_q <= ENV_ONE)
    else $error("envelope value above one");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("output word appeared without a finished computation");
`endif
endmodule
`default_nettype wire

// ===== tb/adsr_envelope_shaper_tb.sv =====
// Self-checking testbench for the ADSR envelope shaper with its own envelope predictor.
module adsr_envelope_shaper_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import adsr_pkg::*;

  localparam int unsigned SW = 16;
  localparam int unsigned LW = 22;
  localparam longint unsigned LEN_MAX = (64'd1 << LW) - 1;
  localparam longint unsigned UNITY = 32768;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned WORD_TARGET = 1200;

  typedef struct packed {
    logic signed [SW-1:0] smp;
    logic                 start;
  } word_t;

  typedef struct packed {
    logic signed [SW-1:0] sample_out;
    phase_e               phase;
  } shaped_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [LW-1:0]     cfg_data;

  adsr_in_if  #(.SAMPLE_WIDTH(SW)) in_if ();
  adsr_out_if #(.SAMPLE_WIDTH(SW)) out_if ();

  adsr_envelope_shaper #(
    .SAMPLE_WIDTH(SW),
    .LENGTH_WIDTH(LW)
  ) u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_i      (in_if),
    .out_o     (out_if)
  );

  // Predictor copy of the registers and the running sample position.
  logic [LW-1:0]   attack_len_q;
  logic [LW-1:0]   decay_len_q;
  logic [15:0]     sustain_q;
  logic [LW-1:0]   release_len_q;
  logic [LW-1:0]   sound_len_q;
  longint unsigned sound_pos;

  word_t   feed_q[$];
  shaped_t shaped_q[$];

  int unsigned words_fed;
  int unsigned words_taken;
  int unsigned words_seen;
  int unsigned err_cnt;
  int unsigned cycle_cnt;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned hold_left;
  int unsigned holds_done;
  int unsigned stall_cnt;

  logic signed [SW-1:0] corner_vals [7];

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = REG_ATTACK_LEN;
    cfg_data       = '0;
    in_if.valid    = 1'b0;
    in_if.sample_in = '0;
    in_if.start_req = 1'b0;
    out_if.ready   = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic shaped_t shape_word(logic signed [SW-1:0] smp, logic start);
    longint unsigned pos, a, d, s, r, len, k, gain;
    longint prod;
    shaped_t res;
    pos = start ? 64'd0 : sound_pos;
    a   = 64'(attack_len_q);
    d   = 64'(decay_len_q);
    len = 64'(sound_len_q);
    s   = (64'(sustain_q) > UNITY) ? UNITY : 64'(sustain_q);
    r   = (64'(release_len_q) > len) ? len : 64'(release_len_q);
    if (pos < a) begin
      res.phase = PH_ATTACK;
      gain = (pos * UNITY) / a;
    end else if (pos < a + d) begin
      res.phase = PH_DECAY;
      gain = UNITY - ((pos - a) * (UNITY - s)) / d;
    end else if (r != 0 && pos > len - r) begin
      // The release ramp ends at the sound length; beyond it the output is silent.
      k = pos - (len - r);
      res.phase = PH_RELEASE;
      gain = (k >= r) ? 64'd0 : (s * (r - k)) / r;
    end else begin
      res.phase = PH_SUSTAIN;
      gain = s;
    end
    prod = longint'(smp) * longint'(gain);
    res.sample_out = SW'(prod >>> 15);
    sound_pos = (pos >= LEN_MAX) ? LEN_MAX : pos + 1;
    return res;
  endfunction

  function automatic logic signed [SW-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return {1'b1, {(SW-1){1'b0}}};
      1: return {1'b0, {(SW-1){1'b1}}};
      2: return '1;
      default: return SW'($urandom);
    endcase
  endfunction

  function automatic longint unsigned rand_len(input int unsigned span);
    case ($urandom_range(0, 19))
      0, 1, 2: return 0;
      3: return $urandom_range(0, 32'(LEN_MAX));
      default: return $urandom_range(1, span);
    endcase
  endfunction

  task automatic queue_word(input logic signed [SW-1:0] smp, input logic start);
    word_t w;
    w.smp   = smp;
    w.start = start;
    feed_q.insert(feed_q.size(), w);
    words_fed++;
  endtask

  task automatic settle();
    while (!(words_taken == words_fed && shaped_q.size() == 0)) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input longint unsigned val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= LW'(val);
    case (idx)
      REG_ATTACK_LEN:  attack_len_q = LW'(val);
      REG_DECAY_LEN:   decay_len_q = LW'(val);
      REG_SUSTAIN_LVL: sustain_q = 16'(val);
      REG_RELEASE_LEN: release_len_q = LW'(val);
      REG_SOUND_LEN:   sound_len_q = LW'(val);
      default: ;
    endcase
  endtask

  task automatic load_setup(input longint unsigned a, d, s, r, l);
    settle();
    put_reg(REG_ATTACK_LEN, a);
    put_reg(REG_DECAY_LEN, d);
    put_reg(REG_SUSTAIN_LVL, s);
    put_reg(REG_RELEASE_LEN, r);
    put_reg(REG_SOUND_LEN, l);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic run_round(input int rnd);
    longint unsigned a, d, s, r, l;
    int unsigned count, run;
    bit broken;
    a = rand_len(24);
    d = rand_len(24);
    r = rand_len(40);
    l = rand_len(80);
    case ($urandom_range(0, 4))
      0: s = 0;
      1: s = UNITY;
      2: s = 16'hFFFF;
      default: s = $urandom_range(0, 65535);
    endcase
    case (rnd)
      0: a = LEN_MAX;
      1: d = LEN_MAX;
      2: begin
        a = 0;
        d = 0;
        r = LEN_MAX;
        l = LEN_MAX;
      end
      3: begin
        r = 0;
        l = LEN_MAX;
      end
      4: l = 0;
      default: ;
    endcase
    load_setup(a, d, s, r, l);
    count = 0;
    // Mostly whole sounds that run a little past their end; now and then one without a start.
    while (count < 90) begin
      run = (l <= 80) ? int'(l) + $urandom_range(0, 6) : $urandom_range(8, 60);
      if (run == 0) run = 1;
      broken = ($urandom_range(0, 9) == 0);
      for (int n = 0; n < run; n++) begin
        queue_word(pick_sample(), (n == 0 && !broken) || $urandom_range(0, 60) == 0);
      end
      count += run;
    end
  endtask

  initial begin : stimulus
    int rnd;
    attack_len_q  = LW'(ATTACK_LEN_RST);
    decay_len_q   = LW'(DECAY_LEN_RST);
    sustain_q     = 16'(SUSTAIN_LVL_RST);
    release_len_q = LW'(RELEASE_LEN_RST);
    sound_len_q   = LW'(SOUND_LEN_RST);
    sound_pos     = 0;
    corner_vals = '{16'sh8000, 16'sh7FFF, -16'sd1, 16'sd1, 16'sd0, 16'sh4000, 16'shCFC7};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings first.
    for (int n = 0; n < 40; n++) queue_word(pick_sample(), n == 0);

    // One short sound through every phase and past its end, then a restart.
    load_setup(3, 3, 16384, 4, 14);
    for (int n = 0; n < 17; n++) queue_word(corner_vals[n % 7], n == 0);
    queue_word(corner_vals[1], 1'b1);

    // No attack or decay, sustain above one, release longer than the sound.
    load_setup(0, 0, 16'hFFFF, 20, 5);
    for (int n = 0; n < 7; n++) queue_word(corner_vals[n], n == 0);

    rnd = 0;
    while (words_fed < WORD_TARGET) begin
      run_round(rnd);
      rnd++;
    end

    settle();
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  always @(posedge clk_i) begin : feeder
    word_t nxt;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        shaped_q.insert(shaped_q.size(), shape_word(in_if.sample_in, in_if.start_req));
        words_taken++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left != 0) begin
          gap_left    <= gap_left - 1;
          in_if.valid <= 1'b0;
        end else if (feed_q.size() != 0) begin
          nxt = feed_q.pop_front();
          in_if.valid     <= 1'b1;
          in_if.sample_in <= nxt.smp;
          in_if.start_req <= nxt.start;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 16);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    shaped_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        words_seen++;
        if (shaped_q.size() == 0) begin
          $error("unexpected word: sample_out %0d phase %0d", out_if.sample_out, out_if.phase);
          err_cnt++;
        end else begin
          want = shaped_q.pop_front();
          if (out_if.sample_out !== want.sample_out) begin
            $error("sample_out: expected %0d, actual %0d", want.sample_out, out_if.sample_out);
            err_cnt++;
          end
          if (out_if.phase !== want.phase) begin
            $error("phase: expected %0d, actual %0d", want.phase, out_if.phase);
            err_cnt++;
          end
        end
      end
      stall_cnt <= stall_cnt + 1;
      // A long hold-off while words are still queued lets the block back up into its input.
      if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        out_if.ready <= 1'b0;
      end else if (holds_done < 2 && words_seen >= 300 + 500 * holds_done &&
                   feed_q.size() > 20) begin
        hold_left    <= 400;
        holds_done   <= holds_done + 1;
        out_if.ready <= 1'b0;
      end else begin
        case (stall_cnt[8:6])
          3'd0, 3'd1, 3'd2: out_if.ready <= 1'b1;
          3'd3, 3'd4: out_if.ready <= 1'($urandom_range(0, 1));
          3'd5: out_if.ready <= ($urandom_range(0, 4) == 0);
          default: out_if.ready <= ($urandom_range(0, 5) != 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule
